/* rtl/spq_pkg.sv */
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OUT_PRIO_W  = 16;
    localparam int OUT_COUNT_W = 5;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_DATA = '1;

    // Operation broadcast to every cell of the chain at once.
    typedef struct packed {
        logic do_push;
        logic do_pop;
    } t_cell_ctl;

endpackage

/* rtl/spq_cell.sv */
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIO_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_new_data,
    input  logic [PRIO_W-1:0]        i_new_prio,
    input  logic                     i_prev_valid,
    input  logic                     i_prev_keep,
    input  logic signed [DATA_W-1:0] i_prev_data,
    input  logic [PRIO_W-1:0]        i_prev_prio,
    input  logic                     i_next_valid,
    input  logic signed [DATA_W-1:0] i_next_data,
    input  logic [PRIO_W-1:0]        i_next_prio,
    output logic                     o_valid,
    output logic                     o_keep,
    output logic signed [DATA_W-1:0] o_data,
    output logic [PRIO_W-1:0]        o_prio
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_data;
    logic [PRIO_W-1:0]        r_prio;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_data;
    logic [PRIO_W-1:0]        n_prio;

    // An entry stays ahead of the new one when its priority is not lower.
    assign o_keep = r_valid && (r_prio >= i_new_prio);

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_prio  = r_prio;
        if (i_ctl.do_pop) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
            n_prio  = i_next_prio;
        end else if (i_ctl.do_push && !o_keep) begin
            if (i_prev_keep) begin
                n_valid = 1'b1;
                n_data  = i_new_data;
                n_prio  = i_new_prio;
            end else begin
                n_valid = i_prev_valid;
                n_data  = i_prev_data;
                n_prio  = i_prev_prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_prio  = r_prio;

endmodule

/* rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue built as a chain of storage cells.
//
// The queue holds up to CAPACITY entries, each a 32-bit data value and a
// priority, kept in a row of cells ordered with the highest priority in
// cell zero. An enqueue item is compared against every cell at once; cells
// whose priority is greater than or equal to the new one keep their entry,
// the first cell that does not keep takes the new entry, and every cell
// behind it takes its left neighbor's entry, so equal priorities leave in
// arrival order. A dequeue item makes every cell take its right neighbor's
// entry. Each item updates the cell row and produces exactly one result
// item in the cycle after it is accepted; one item per cycle is
// sustained while the result side does not stall. The input stalls only
// while a result is held and the result side stalls. An enqueue on a full
// queue is dropped with status 2, a dequeue on an empty queue returns
// status 1; both return -1 as removed data. The head fields and the count
// shown with a result describe the queue after that item. Priorities keep
// only their low PRIORITY_WIDTH bits.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY       = 16,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic signed [DATA_W-1:0]      i_item_data,
    input  logic [OUT_PRIO_W-1:0]         i_item_priority,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [DATA_W-1:0]      o_removed_data,
    output logic                          o_head_valid,
    output logic signed [DATA_W-1:0]      o_head_data,
    output logic [OUT_PRIO_W-1:0]         o_head_priority,
    output logic [OUT_COUNT_W-1:0]        o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CAPACITY-1:0]             cell_valid;
    logic [CAPACITY-1:0]             cell_keep;
    logic signed [DATA_W-1:0]        cell_data [CAPACITY];
    logic [PRIORITY_WIDTH-1:0]       cell_prio [CAPACITY];

    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic                            r_out_valid;
    logic [STATUS_W-1:0]             r_status;
    logic signed [DATA_W-1:0]        r_removed;

    logic                            accept;
    logic                            full;
    logic                            empty;
    t_cell_ctl                       ctl;
    logic [31:0]                     prio_wide;
    logic [PRIORITY_WIDTH-1:0]       new_prio;
    logic [31:0]                     head_prio_wide;
    logic [31:0]                     count_wide;

    // The input is held back only while a result waits and cannot leave.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    assign ctl.do_push = accept && (i_command == CMD_PUSH) && !full;
    assign ctl.do_pop  = accept && (i_command == CMD_POP) && !empty;

    // Keep only the low PRIORITY_WIDTH bits of the incoming priority.
    assign prio_wide = 32'(i_item_priority);
    assign new_prio  = prio_wide[PRIORITY_WIDTH-1:0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     prev_valid;
        logic                     prev_keep;
        logic signed [DATA_W-1:0] prev_data;
        logic [PRIORITY_WIDTH-1:0] prev_prio;
        logic                     next_valid;
        logic signed [DATA_W-1:0] next_data;
        logic [PRIORITY_WIDTH-1:0] next_prio;

        if (g == 0) begin : g_first
            // The head cell sees a virtual neighbor that always keeps.
            assign prev_valid = 1'b1;
            assign prev_keep  = 1'b1;
            assign prev_data  = i_item_data;
            assign prev_prio  = new_prio;
        end else begin : g_mid
            assign prev_valid = cell_valid[g-1];
            assign prev_keep  = cell_keep[g-1];
            assign prev_data  = cell_data[g-1];
            assign prev_prio  = cell_prio[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // A dequeue empties the tail cell.
            assign next_valid = 1'b0;
            assign next_data  = cell_data[g];
            assign next_prio  = cell_prio[g];
        end else begin : g_inner
            assign next_valid = cell_valid[g+1];
            assign next_data  = cell_data[g+1];
            assign next_prio  = cell_prio[g+1];
        end

        spq_cell #(
            .PRIO_W (PRIORITY_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_new_data   (i_item_data),
            .i_new_prio   (new_prio),
            .i_prev_valid (prev_valid),
            .i_prev_keep  (prev_keep),
            .i_prev_data  (prev_data),
            .i_prev_prio  (prev_prio),
            .i_next_valid (next_valid),
            .i_next_data  (next_data),
            .i_next_prio  (next_prio),
            .o_valid      (cell_valid[g]),
            .o_keep       (cell_keep[g]),
            .o_data       (cell_data[g]),
            .o_prio       (cell_prio[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctl.do_push) begin
            n_count = r_count + 1'b1;
        end else if (ctl.do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Result register: status and removed data are captured with the item,
    // while the head and count follow the cells, which only move on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            if (i_command == CMD_PUSH) begin
                r_status  <= full ? ST_REFUSED : ST_DONE;
                r_removed <= EMPTY_DATA;
            end else begin
                r_status  <= empty ? ST_EMPTY : ST_DONE;
                r_removed <= empty ? EMPTY_DATA : cell_data[0];
            end
        end
    end

    assign head_prio_wide = 32'(cell_prio[0]);
    assign count_wide     = 32'(r_count);

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_data  = r_removed;
    assign o_head_valid    = cell_valid[0];
    assign o_head_data     = cell_valid[0] ? cell_data[0] : EMPTY_DATA;
    assign o_head_priority = cell_valid[0] ? head_prio_wide[OUT_PRIO_W-1:0] : '0;
    assign o_entry_count   = count_wide[OUT_COUNT_W-1:0];

`ifndef NO_ASSERTIONS
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(cell_valid)))
        else $error("entry count disagrees with occupied cells");

    a_head_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_valid[1] |-> (cell_valid[0] && cell_prio[0] >= cell_prio[1]))
        else $error("head cell out of priority order");

    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_PUSH && full) |=> (r_status == ST_REFUSED &&
            $stable(r_count)))
        else $error("refused enqueue changed the queue");

    a_empty_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_POP && empty) |=> (r_status == ST_EMPTY &&
            r_removed == EMPTY_DATA))
        else $error("dequeue on empty queue reported wrongly");
`endif

endmodule
